// ----- src/assert_macros.svh -----
// Assertion macros for the RTL of the archive block decryptor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising edge of aclk, off while aresetn is low.
`define ABD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same, but also checked while reset is asserted.
`define ABD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- src/abd_pkg.sv -----
// Package with the constants and the fixed mixing table of the block decryptor.
package abd_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned TABLE_DEPTH = 256;

    localparam logic [WORD_W-1:0] SEED_START = 32'hEEEE_EEEE;
    localparam logic [WORD_W-1:0] KEY_MIX    = 32'h1111_1111;
    localparam logic [WORD_W-1:0] SEED_ADD   = 32'd3;
    localparam int unsigned       KEY_SHL    = 21;
    localparam int unsigned       KEY_SHR    = 11;
    localparam int unsigned       SEED_SHL   = 5;

    // Table generator: a linear congruential sequence; each word takes two steps.
    localparam logic [WORD_W-1:0] GEN_START  = 32'h0010_0001;
    localparam logic [WORD_W-1:0] GEN_MOD    = 32'h002A_AAAB;
    localparam logic [WORD_W-1:0] GEN_MUL    = 32'd125;
    localparam logic [WORD_W-1:0] GEN_ADD    = 32'd3;
    localparam int unsigned       GEN_GROUPS = 5;

    typedef logic [WORD_W-1:0] mix_tbl_t [TABLE_DEPTH];

    // Evaluated at elaboration only; each table word is the fifth word of a group of five generator words.
    function automatic mix_tbl_t build_mix_table();
        mix_tbl_t          tbl;
        logic [WORD_W-1:0] s;
        logic [WORD_W-1:0] hi;
        s  = GEN_START;
        hi = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            for (int g = 0; g < GEN_GROUPS; g++) begin
                s  = (s * GEN_MUL + GEN_ADD) % GEN_MOD;
                hi = {s[15:0], 16'h0000};
                s  = (s * GEN_MUL + GEN_ADD) % GEN_MOD;
                tbl[i] = hi | {16'h0000, s[15:0]};
            end
        end
        return tbl;
    endfunction

    localparam mix_tbl_t MIX_TABLE = build_mix_table();

endpackage

// ----- src/abd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module abd_ram #(
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/archive_block_decryptor.sv -----
// Top level of the archive block decryptor: key/seed recurrence, table RAM and output skid.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         tvalid / tready    tdata = cipher_word, tlast = last_word
//  m_        out        tvalid / tready    tdata = plain_word,  tlast = block_end
//  cfg_      in         cfg_we             cfg_wdata = block_key
//
// One item per cycle while s_tready is high; an accepted result is registered in the output
// register, or in the skid entry while that register is stalled. After reset the table RAM
// is loaded from the package table, and no item is accepted before the load is done and the
// first table read is registered. The table entry for the next item is read ahead; a key
// change the read did not see (a new block_key) stalls the input until the entry is read anew.
// A two-entry output stage lets one more item in while the result is stalled.
`include "assert_macros.svh"

module archive_block_decryptor #(
    parameter int unsigned TABLE_DEPTH = abd_pkg::TABLE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [abd_pkg::WORD_W-1:0] cfg_wdata,     // block_key
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [abd_pkg::WORD_W-1:0] s_tdata,       // [31:0] cipher_word
    input  logic                       s_tlast,       // last_word
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [abd_pkg::WORD_W-1:0] m_tdata,       // [31:0] plain_word
    output logic                       m_tlast        // block_end
);

    import abd_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

    logic [WORD_W-1:0] block_key_reg;
    logic [WORD_W-1:0] running_key_reg, running_key_next;
    logic [WORD_W-1:0] running_seed_reg, running_seed_next;
    logic              in_block_reg, in_block_next;

    logic [IDX_W:0]    fill_cnt_reg;
    logic              fill_done;

    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  rd_addr_reg;
    logic              rd_ok_reg;
    logic [WORD_W-1:0] tbl_word;

    logic [WORD_W-1:0] cur_key, cur_seed, seed_mix, plain, key_new, seed_new, next_key;
    logic              hit, accept, m_take;

    logic [WORD_W-1:0] out_data_reg, skid_data_reg;
    logic              out_last_reg, skid_last_reg;
    logic              out_valid_reg, skid_valid_reg;

    // Table RAM, loaded once after reset.
    assign fill_done = fill_cnt_reg[IDX_W];

    abd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_mix_ram (
        .aclk    (aclk),
        .wr_en   (!fill_done),
        .wr_addr (fill_cnt_reg[IDX_W-1:0]),
        .wr_data (MIX_TABLE[fill_cnt_reg[IDX_W-1:0]]),
        .rd_addr (rd_addr),
        .rd_data (tbl_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_cnt_reg <= '0;
            rd_ok_reg    <= 1'b0;
        end else begin
            if (!fill_done) begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
            end
            rd_ok_reg <= fill_done;
        end
        rd_addr_reg <= rd_addr;
    end

    // Word recurrence.
    always_comb begin
        cur_key  = in_block_reg ? running_key_reg  : block_key_reg;
        cur_seed = in_block_reg ? running_seed_reg : SEED_START;
        seed_mix = cur_seed + tbl_word;
        plain    = s_tdata ^ (cur_key + seed_mix);
        key_new  = ((~cur_key << KEY_SHL) + KEY_MIX) | (cur_key >> KEY_SHR);
        seed_new = plain + seed_mix + (seed_mix << SEED_SHL) + SEED_ADD;
    end

    // The registered table word is usable only if it was read for the current key.
    assign hit      = rd_ok_reg && (rd_addr_reg == cur_key[IDX_W-1:0]);
    assign s_tready = fill_done && hit && !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_take   = out_valid_reg && m_tready;

    always_comb begin
        running_key_next  = running_key_reg;
        running_seed_next = running_seed_reg;
        in_block_next     = in_block_reg;
        next_key          = cur_key;
        if (accept) begin
            if (s_tlast) begin
                in_block_next = 1'b0;
                next_key      = block_key_reg;
            end else begin
                running_key_next  = key_new;
                running_seed_next = seed_new;
                in_block_next     = 1'b1;
                next_key          = key_new;
            end
        end
        rd_addr = next_key[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_key_reg    <= '0;
            running_key_reg  <= '0;
            running_seed_reg <= SEED_START;
            in_block_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                block_key_reg <= cfg_wdata;
            end
            running_key_reg  <= running_key_next;
            running_seed_reg <= running_seed_next;
            in_block_reg     <= in_block_next;
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_take) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (accept) begin
                if (!out_valid_reg || m_take) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_take) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (skid_valid_reg) begin
            if (m_take) begin
                out_data_reg <= skid_data_reg;
                out_last_reg <= skid_last_reg;
            end
        end else if (accept) begin
            if (!out_valid_reg || m_take) begin
                out_data_reg <= plain;
                out_last_reg <= s_tlast;
            end else begin
                skid_data_reg <= plain;
                skid_last_reg <= s_tlast;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `ABD_ASSERT(a_no_accept_in_fill, accept |-> fill_done, "item accepted during table load")
    `ABD_ASSERT(a_skid_behind_out, skid_valid_reg |-> out_valid_reg, "skid entry without output entry")
    `ABD_ASSERT(a_table_addr_match, accept |-> (rd_addr_reg == cur_key[IDX_W-1:0]), "stale table word used")
    `ABD_ASSERT(a_last_ends_block, (accept && s_tlast) |=> !in_block_reg, "block not closed after last item")

endmodule

// ----- tb/tb_archive_block_decryptor.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the archive block decryptor: directed and random streams against a predictor.
module tb_archive_block_decryptor;

    typedef logic [abd_pkg::WORD_W-1:0] word_t;
    typedef struct packed {
        word_t data;
        logic  last;
    } beat_t;

    logic  aclk      = 1'b0;
    logic  aresetn   = 1'b0;
    logic  cfg_we    = 1'b0;
    word_t cfg_wdata = '0;
    logic  s_tvalid  = 1'b0;
    logic  s_tready;
    word_t s_tdata   = '0;
    logic  s_tlast   = 1'b0;
    logic  m_tvalid;
    logic  m_tready  = 1'b0;
    word_t m_tdata;
    logic  m_tlast;

    archive_block_decryptor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    word_t mix_tbl [abd_pkg::TABLE_DEPTH];
    word_t key_reg;
    word_t chain_seed;
    word_t chain_key;
    bit    mid_block;

    beat_t cipher_q [$];
    beat_t plain_q [$];

    bit src_idle_en;
    bit snk_idle_en;
    int src_gap        = 0;
    int snk_gap        = 0;
    int hold_left      = 0;
    int hold_served    = 0;
    int hold_requests  = 0;
    int mismatch_count = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The table is the fifth word of every group of five generator words.
    function automatic void fill_mix_table();
        word_t s;
        word_t w;
        s = abd_pkg::GEN_START;
        w = '0;
        for (int n = 0; n < abd_pkg::GEN_GROUPS * abd_pkg::TABLE_DEPTH; n++) begin
            s = (s * abd_pkg::GEN_MUL + abd_pkg::GEN_ADD) % abd_pkg::GEN_MOD;
            w[31:16] = s[15:0];
            s = (s * abd_pkg::GEN_MUL + abd_pkg::GEN_ADD) % abd_pkg::GEN_MOD;
            w[15:0] = s[15:0];
            if (n % abd_pkg::GEN_GROUPS == abd_pkg::GEN_GROUPS - 1)
                mix_tbl[n / abd_pkg::GEN_GROUPS] = w;
        end
    endfunction

    function automatic void decrypt_word(input word_t cw, input logic last);
        word_t seed;
        word_t key;
        word_t plain;
        if (!mid_block) begin
            chain_seed = abd_pkg::SEED_START;
            chain_key  = key_reg;
        end
        seed  = chain_seed + mix_tbl[chain_key[7:0]];
        plain = cw ^ (chain_key + seed);
        key   = ((~chain_key << abd_pkg::KEY_SHL) + abd_pkg::KEY_MIX)
                | (chain_key >> abd_pkg::KEY_SHR);
        seed  = plain + seed + (seed << abd_pkg::SEED_SHL) + abd_pkg::SEED_ADD;
        if (last) begin
            mid_block = 1'b0;
        end else begin
            chain_seed = seed;
            chain_key  = key;
            mid_block  = 1'b1;
        end
        plain_q.push_back(beat_t'{plain, last});
    endfunction

    task automatic note_mismatch(input string field, input word_t want, input word_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s at %0t: expected %h, got %h", field, $realtime, want, got);
    endtask

    // Driver: offers pending items and records the expectation of each accepted one.
    always @(posedge aclk) begin
        beat_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                decrypt_word(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (cipher_q.size() > 0) begin
                    nxt = cipher_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                    if (src_idle_en && $urandom_range(0, 7) == 0)
                        src_gap = $urandom_range(1, 19);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every accepted item on the result side and paces m_tready.
    always @(posedge aclk) begin
        beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (plain_q.size() == 0) begin
                    note_mismatch("plain_word (no item expected)", '0, m_tdata);
                end else begin
                    want = plain_q.pop_front();
                    if (m_tdata !== want.data)
                        note_mismatch("plain_word", want.data, m_tdata);
                    if (m_tlast !== want.last)
                        note_mismatch("block_end", word_t'(want.last), word_t'(m_tlast));
                end
            end
            if (snk_gap > 0)
                snk_gap--;
            else if (snk_idle_en && $urandom_range(0, 7) == 0)
                snk_gap = $urandom_range(1, 19);
            m_tready <= (snk_gap == 0) && (hold_left == 0);
        end
    end

    // Long receiver hold-off, long enough for the block to fill and stall its input.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_left   <= 400;
            hold_served <= hold_served + 1;
        end
    end

    task automatic settle();
        while (cipher_q.size() != 0 || s_tvalid || plain_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_block_key(input word_t k);
        settle();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        key_reg    = k;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_block(input int len, input bit close);
        word_t w;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 15))
                0: w = '0;
                1: w = '1;
                default: w = $urandom();
            endcase
            cipher_q.push_back(beat_t'{w, close && (i == len - 1)});
        end
    endtask

    initial begin
        int    total;
        int    len;
        bit    close;
        word_t k;
        fill_mix_table();
        key_reg     = '0;
        chain_seed  = abd_pkg::SEED_START;
        chain_key   = '0;
        mid_block   = 1'b0;
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Single-word blocks and a short block with extreme words.
        load_block_key(32'hFFFF_FFFF);
        cipher_q.push_back(beat_t'{32'h0000_0000, 1'b1});
        cipher_q.push_back(beat_t'{32'hFFFF_FFFF, 1'b1});
        cipher_q.push_back(beat_t'{32'h0000_0000, 1'b0});
        cipher_q.push_back(beat_t'{32'hFFFF_FFFF, 1'b0});
        cipher_q.push_back(beat_t'{32'hA5A5_A5A5, 1'b1});

        // A key written in the middle of a block applies only from the next block on.
        load_block_key(32'h0000_0000);
        cipher_q.push_back(beat_t'{32'h1234_5678, 1'b0});
        cipher_q.push_back(beat_t'{32'h8765_4321, 1'b0});
        load_block_key(32'hDEAD_BEEF);
        cipher_q.push_back(beat_t'{32'h0F0F_0F0F, 1'b0});
        cipher_q.push_back(beat_t'{32'hF0F0_F0F0, 1'b1});
        cipher_q.push_back(beat_t'{32'h5555_5555, 1'b0});
        cipher_q.push_back(beat_t'{32'hAAAA_AAAA, 1'b1});

        // Highest table index on the first word.
        load_block_key(32'h0000_00FF);
        cipher_q.push_back(beat_t'{32'h0000_0001, 1'b1});
        cipher_q.push_back(beat_t'{32'h8000_0000, 1'b0});
        cipher_q.push_back(beat_t'{32'h7FFF_FFFF, 1'b0});
        cipher_q.push_back(beat_t'{32'hFFFF_FFFE, 1'b1});

        // Random phases; a phase may end inside a block, so the next key lands mid-block.
        for (int p = 0; p < 10; p++) begin
            case (p)
                0: k = 32'h0000_0000;
                1: k = 32'hFFFF_FFFF;
                default: k = $urandom();
            endcase
            src_idle_en = (p < 8) && (p != 3) && (p != 4);
            snk_idle_en = (p < 8) && (p != 3) && (p != 4);
            load_block_key(k);
            if (p == 4)
                hold_requests++;
            total = 0;
            while (total < 140) begin
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(17, 64);
                else
                    len = $urandom_range(1, 16);
                close = (total + len < 140) || ($urandom_range(0, 1) == 1);
                queue_block(len, close);
                total += len;
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && plain_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

endmodule
